// ----- rtl/core/random_walk_token_relay_node_unit_defines.svh -----
// Assertion macros shared by the checker.
`ifndef RANDOM_WALK_TOKEN_RELAY_NODE_UNIT_DEFINES_SVH
`define RANDOM_WALK_TOKEN_RELAY_NODE_UNIT_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define RW_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RW_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/rwtr_pkg.sv -----
package rwtr_pkg;
  localparam logic [2:0] ACT_TICK = 3'd0;
  localparam logic [2:0] ACT_ANNOUNCE = 3'd1;
  localparam logic [2:0] ACT_RECOVER = 3'd2;
  localparam logic [2:0] ACT_BEACON = 3'd3;
  localparam logic [2:0] ACT_DATA = 3'd4;
  localparam logic [2:0] ACT_CONTROL = 3'd5;
  localparam logic [2:0] ACT_START = 3'd6;
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_RECOVER = 2'd1;
  localparam logic [1:0] KIND_CONTROL = 2'd2;
  localparam logic [1:0] KIND_DATA = 2'd3;
  localparam logic CFG_SINK_MODE = 1'b0;
  localparam logic CFG_LIFETIME = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_MOD, ST_FETCH, ST_WAIT, ST_OUT
  } state_t;
endpackage

// ----- rtl/core/rwtr_table_mem.sv -----
module rwtr_table_mem
  import rwtr_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ----- rtl/core/random_walk_token_relay_node_unit.sv -----
// Channel | Ports                                   | Transfer
// input   | start, busy, in_* fields                | start && !busy
// result  | out_valid, out_* fields                 | out_valid, one cycle
// config  | cfg_we, cfg_index, cfg_data             | cfg_we
// Tick and announce keep busy high while the walk reads one entry a cycle from the
// neighbour memory; a full-table walk is the longest case. Data and start work out
// random_value mod count in the serial remainder unit, then pass a fetch and a wait state.
// The other actions go straight to the output state. A new start is taken only once busy is low.
// Reset (rst_n low, synchronous) empties the table and clears token and version;
// the memory itself needs no clearing pass, as entries beyond the count are never read.
// The receiver cannot stall: each result is shown with out_valid for a single cycle.
module random_walk_token_relay_node_unit
  import rwtr_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int NODE_ID_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_action,
  input  logic [15:0]        in_source_node,
  input  logic signed [15:0] in_msg_version,
  input  logic signed [31:0] in_msg_token,
  input  logic signed [31:0] in_msg_hops,
  input  logic [15:0]        in_random_value,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  output logic [1:0]         out_send_kind,
  output logic [15:0]        out_dest_node,
  output logic signed [15:0] out_out_version,
  output logic signed [31:0] out_out_token,
  output logic signed [31:0] out_out_hops,
  output logic [4:0]         out_neighbor_total
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = NODE_ID_BITS + 16;
  localparam int IDW = (NODE_ID_BITS < 16) ? NODE_ID_BITS : 16;

  state_t state_r, state_nxt;
  logic sink_r;
  logic [15:0] life_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] tok_r, tok_nxt;
  logic [15:0] ver_r, ver_nxt;
  // Latched item.
  logic [2:0] act_r;
  logic [NODE_ID_BITS-1:0] src_r;
  logic [15:0] mver_r, rnd_r;
  logic [31:0] mtok_r, mhops_r;
  // Walk state: read pointer, write pointer, pipelined read valid, hit flag.
  logic [CW-1:0] rp_r, rp_nxt, wp_r, wp_nxt;
  logic rv_r, rv_nxt, hit_r, hit_nxt;
  logic [AW-1:0] rva_r, rva_nxt;
  // Modulo remainder unit.
  logic [CW-1:0] rem_r, rem_nxt;
  logic [4:0] bit_r, bit_nxt;
  logic [CW:0] trial;
  // Result registers.
  logic ov_r, ov_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [15:0] dst_r, dst_nxt, over_r, over_nxt;
  logic [31:0] otok_r, otok_nxt, ohops_r, ohops_nxt;

  logic we;
  logic [AW-1:0] wa, ra;
  logic [EW-1:0] wd, rd;
  logic [15:0] rd_tim;
  logic [NODE_ID_BITS-1:0] rd_id;

  assign rd_id = rd[EW-1:16];
  assign rd_tim = rd[15:0];

  rwtr_table_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(EW)) u_mem (
    .clk(clk), .wr_en(we), .wr_addr(wa), .wr_data(wd), .rd_addr(ra), .rd_data(rd)
  );

  assign trial = {rem_r, rnd_r[bit_r[3:0]]} - {1'b0, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sink_r <= 1'b0;
      life_r <= 16'd30;
      cnt_r <= '0;
      tok_r <= '0;
      ver_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      tok_r <= tok_nxt;
      ver_r <= ver_nxt;
      ov_r <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SINK_MODE: sink_r <= cfg_data[0];
          CFG_LIFETIME: life_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act_r <= in_action;
      src_r <= NODE_ID_BITS'(in_source_node);
      mver_r <= in_msg_version;
      mtok_r <= in_msg_token;
      mhops_r <= in_msg_hops;
      rnd_r <= in_random_value;
    end
    rp_r <= rp_nxt;
    wp_r <= wp_nxt;
    rv_r <= rv_nxt;
    rva_r <= rva_nxt;
    hit_r <= hit_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
    kind_r <= kind_nxt;
    dst_r <= dst_nxt;
    over_r <= over_nxt;
    otok_r <= otok_nxt;
    ohops_r <= ohops_nxt;
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    tok_nxt = tok_r;
    ver_nxt = ver_r;
    rp_nxt = rp_r;
    wp_nxt = wp_r;
    rv_nxt = 1'b0;
    rva_nxt = rva_r;
    hit_nxt = hit_r;
    rem_nxt = rem_r;
    bit_nxt = bit_r;
    ov_nxt = 1'b0;
    kind_nxt = kind_r;
    dst_nxt = dst_r;
    over_nxt = over_r;
    otok_nxt = otok_r;
    ohops_nxt = ohops_r;
    we = 1'b0;
    wa = '0;
    wd = '0;
    ra = rp_r[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          rp_nxt = '0;
          wp_nxt = '0;
          hit_nxt = 1'b0;
          rem_nxt = '0;
          bit_nxt = 5'd15;
          kind_nxt = KIND_NONE;
          dst_nxt = '0;
          over_nxt = '0;
          otok_nxt = '0;
          ohops_nxt = '0;
          state_nxt = ST_SCAN;
          case (in_action)
            ACT_TICK, ACT_ANNOUNCE: state_nxt = ST_SCAN;
            ACT_DATA, ACT_START: state_nxt = ST_MOD;
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_SCAN: begin
        // Read one entry a cycle; the memory read is registered, so rv_r marks when its data arrives.
        if (rp_r < cnt_r && !hit_r) begin
          rp_nxt = rp_r + 1'b1;
          rv_nxt = 1'b1;
          rva_nxt = rp_r[AW-1:0];
        end
        if (rv_r) begin
          if (act_r == ACT_TICK) begin
            if (rd_tim > 16'd1) begin
              we = 1'b1;
              wa = wp_r[AW-1:0];
              wd = {rd_id, rd_tim - 16'd1};
              wp_nxt = wp_r + 1'b1;
            end
          end else if (!hit_r && rd_id == src_r) begin
            we = 1'b1;
            wa = rva_r;
            wd = {rd_id, life_r};
            hit_nxt = 1'b1;
            rv_nxt = 1'b0;
          end
        end
        if (!rv_r && (rp_r >= cnt_r || hit_r)) begin
          if (act_r == ACT_TICK) begin
            cnt_nxt = wp_r;
          end else if (!hit_r && cnt_r < CW'(TABLE_DEPTH)) begin
            we = 1'b1;
            wa = cnt_r[AW-1:0];
            wd = {src_r, life_r};
            cnt_nxt = cnt_r + 1'b1;
          end
          state_nxt = ST_OUT;
        end
      end
      ST_MOD: begin
        // Restoring remainder, one bit of random_value per cycle.
        if (cnt_r != '0) begin
          if (!trial[CW]) rem_nxt = trial[CW-1:0];
          else rem_nxt = CW'({rem_r, rnd_r[bit_r[3:0]]});
        end
        bit_nxt = bit_r - 5'd1;
        if (bit_r == 5'd0) state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        ra = rem_r[AW-1:0];
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (act_r == ACT_DATA) begin
          tok_nxt = mtok_r;
          ver_nxt = mver_r;
          if (!sink_r && cnt_r != '0) begin
            kind_nxt = KIND_DATA;
            dst_nxt = 16'(rd_id[IDW-1:0]);
            over_nxt = mver_r;
            otok_nxt = mtok_r;
            ohops_nxt = mhops_r + 32'd1;
          end
        end else begin
          tok_nxt = tok_r + 32'd1;
          ver_nxt = ver_r + 16'd1;
          if (cnt_r != '0) begin
            kind_nxt = KIND_DATA;
            dst_nxt = 16'(rd_id[IDW-1:0]);
            over_nxt = ver_r + 16'd1;
            otok_nxt = tok_r + 32'd1;
          end
        end
        ov_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_OUT: begin
        case (act_r)
          ACT_RECOVER: begin
            tok_nxt = mtok_r;
            ver_nxt = mver_r;
          end
          ACT_BEACON: begin
            if ($signed(ver_r) > $signed(mver_r)) begin
              kind_nxt = KIND_RECOVER;
              otok_nxt = tok_r;
              ohops_nxt = '1;
            end else if ($signed(ver_r) < $signed(mver_r)) begin
              kind_nxt = KIND_CONTROL;
            end
            dst_nxt = ($signed(ver_r) != $signed(mver_r)) ? 16'(src_r[IDW-1:0]) : '0;
            over_nxt = ($signed(ver_r) != $signed(mver_r)) ? ver_r : '0;
          end
          ACT_CONTROL: begin
            kind_nxt = KIND_RECOVER;
            dst_nxt = 16'(src_r[IDW-1:0]);
            over_nxt = ver_r;
            otok_nxt = tok_r;
            ohops_nxt = '1;
          end
          default: ;
        endcase
        ov_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_send_kind = kind_r;
  assign out_dest_node = dst_r;
  assign out_out_version = over_r;
  assign out_out_token = otok_r;
  assign out_out_hops = ohops_r;
  assign out_neighbor_total = 5'(cnt_r);
endmodule

// ----- rtl/core/rwtr_checker.sv -----
`include "random_walk_token_relay_node_unit_defines.svh"
module rwtr_checker
  import rwtr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_send_kind,
  input logic [15:0] out_dest_node,
  input logic [31:0] out_out_hops,
  input logic [4:0]  out_neighbor_total
);
  `RW_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `RW_ASSERT_NXT(a_one_cycle, clk, rst_n, out_valid, !out_valid)
  `RW_ASSERT_IMP(a_none_zero, clk, rst_n, out_valid && out_send_kind == KIND_NONE,
    out_dest_node == 16'd0 && out_out_hops == 32'd0)
  `RW_ASSERT_IMP(a_total_range, clk, rst_n, 1'b1, out_neighbor_total <= 5'd16)
endmodule

bind random_walk_token_relay_node_unit rwtr_checker u_rwtr_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_send_kind(out_send_kind), .out_dest_node(out_dest_node),
  .out_out_hops(out_out_hops), .out_neighbor_total(out_neighbor_total)
);

// ----- tb/sv/tb_random_walk_token_relay_node_unit.sv -----
module tb_random_walk_token_relay_node_unit;
  import rwtr_pkg::*;

  // One message or tick as presented to the node.
  typedef struct {
    logic [2:0]         action;
    logic [15:0]        source_node;
    logic signed [15:0] msg_version;
    logic signed [31:0] msg_token;
    logic signed [31:0] msg_hops;
    logic [15:0]        random_value;
  } msg_item_t;

  // What the node is expected to send after one item.
  typedef struct {
    logic [1:0]         send_kind;
    logic [15:0]        dest_node;
    logic signed [15:0] out_version;
    logic signed [31:0] out_token;
    logic signed [31:0] out_hops;
    logic [4:0]         neighbor_total;
  } send_item_t;

  localparam int DEPTH = 16;
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_action;
  logic [15:0]        in_source_node;
  logic signed [15:0] in_msg_version;
  logic signed [31:0] in_msg_token;
  logic signed [31:0] in_msg_hops;
  logic [15:0]        in_random_value;
  logic               cfg_we;
  logic               cfg_index;
  logic [15:0]        cfg_data;
  logic               out_valid;
  logic [1:0]         out_send_kind;
  logic [15:0]        out_dest_node;
  logic signed [15:0] out_out_version;
  logic signed [31:0] out_out_token;
  logic signed [31:0] out_out_hops;
  logic [4:0]         out_neighbor_total;

  random_walk_token_relay_node_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_source_node(in_source_node),
    .in_msg_version(in_msg_version), .in_msg_token(in_msg_token),
    .in_msg_hops(in_msg_hops), .in_random_value(in_random_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_send_kind(out_send_kind),
    .out_dest_node(out_dest_node), .out_out_version(out_out_version),
    .out_out_token(out_out_token), .out_out_hops(out_out_hops),
    .out_neighbor_total(out_neighbor_total)
  );

  // The node's state as the testbench believes it to be.
  logic [15:0] nbr_id [DEPTH];
  logic [15:0] nbr_timer [DEPTH];
  int          nbr_count;
  logic [31:0] token_held;
  logic [15:0] version_held;
  logic        sink_cfg;
  logic [15:0] lifetime_cfg;

  msg_item_t  pending_msgs[$];
  send_item_t expected_sends[$];
  int         error_count;
  int         gap_left;
  bit         drain_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one item to the predicted state and queues the send it causes.
  function automatic void predict_relay(input msg_item_t m);
    send_item_t s;
    int         w;
    s = '{KIND_NONE, 16'd0, 16'sd0, 32'sd0, 32'sd0, 5'd0};
    case (m.action)
      ACT_TICK: begin
        // Expired entries drop out while the survivors keep their order.
        w = 0;
        for (int r = 0; r < nbr_count; r++) begin
          if (nbr_timer[r] > 16'd1) begin
            nbr_id[w] = nbr_id[r];
            nbr_timer[w] = nbr_timer[r] - 16'd1;
            w++;
          end
        end
        nbr_count = w;
      end
      ACT_ANNOUNCE: begin
        w = -1;
        for (int i = 0; i < nbr_count; i++)
          if (w < 0 && nbr_id[i] == m.source_node) w = i;
        if (w >= 0) begin
          nbr_timer[w] = lifetime_cfg;
        end else if (nbr_count < DEPTH) begin
          // A full table ignores announces from strangers.
          nbr_id[nbr_count] = m.source_node;
          nbr_timer[nbr_count] = lifetime_cfg;
          nbr_count++;
        end
      end
      ACT_RECOVER: begin
        token_held = m.msg_token;
        version_held = m.msg_version;
      end
      ACT_BEACON: begin
        // Equal versions leave the beacon unanswered.
        if ($signed(version_held) > m.msg_version)
          s = '{KIND_RECOVER, m.source_node, version_held, token_held, -32'sd1, 5'd0};
        else if ($signed(version_held) < m.msg_version)
          s = '{KIND_CONTROL, m.source_node, version_held, 32'sd0, 32'sd0, 5'd0};
      end
      ACT_DATA: begin
        token_held = m.msg_token;
        version_held = m.msg_version;
        if (!sink_cfg && nbr_count > 0)
          s = '{KIND_DATA, nbr_id[m.random_value % nbr_count], m.msg_version,
                m.msg_token, m.msg_hops + 32'sd1, 5'd0};
      end
      ACT_CONTROL: begin
        s = '{KIND_RECOVER, m.source_node, version_held, token_held, -32'sd1, 5'd0};
      end
      ACT_START: begin
        token_held = token_held + 32'd1;
        version_held = version_held + 16'd1;
        if (nbr_count > 0)
          s = '{KIND_DATA, nbr_id[m.random_value % nbr_count], version_held,
                token_held, 32'sd0, 5'd0};
      end
      default: ;
    endcase
    s.neighbor_total = nbr_count[4:0];
    expected_sends.push_back(s);
  endfunction

  function automatic msg_item_t make_msg(input logic [2:0] act, input logic [15:0] src,
                                         input logic [15:0] ver, input logic [31:0] tok,
                                         input logic [31:0] hops, input logic [15:0] rnd);
    msg_item_t m;
    m.action = act;
    m.source_node = src;
    m.msg_version = ver;
    m.msg_token = tok;
    m.msg_hops = hops;
    m.random_value = rnd;
    return m;
  endfunction

  function automatic msg_item_t random_msg(input logic [2:0] act);
    return make_msg(act, 16'($urandom_range(0, 23)), 16'($urandom), $urandom, $urandom,
                    16'($urandom));
  endfunction

  // Driver: one transfer per accepted start, then a random gap or the next item back to back.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      predict_relay(make_msg(in_action, in_source_node, in_msg_version, in_msg_token,
                             in_msg_hops, in_random_value));
      if ($urandom_range(0, 3) == 0 && pending_msgs.size() > 0 && !drain_hold) begin
        // Back to back: keep start high and present the next item at once.
        {in_action, in_source_node, in_msg_version, in_msg_token, in_msg_hops,
         in_random_value} <= {pending_msgs[0].action, pending_msgs[0].source_node,
         pending_msgs[0].msg_version, pending_msgs[0].msg_token,
         pending_msgs[0].msg_hops, pending_msgs[0].random_value};
        void'(pending_msgs.pop_front());
        gap_left <= 0;
      end else begin
        gap_left <= $urandom_range(0, 3);
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_msgs.size() > 0 && !drain_hold) begin
        start <= 1'b1;
        {in_action, in_source_node, in_msg_version, in_msg_token, in_msg_hops,
         in_random_value} <= {pending_msgs[0].action, pending_msgs[0].source_node,
         pending_msgs[0].msg_version, pending_msgs[0].msg_token,
         pending_msgs[0].msg_hops, pending_msgs[0].random_value};
        void'(pending_msgs.pop_front());
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin
    send_item_t e;
    if (rst_n && out_valid) begin
      if (expected_sends.size() == 0) begin
        $error("unexpected result transfer, kind %0d", out_send_kind);
        error_count++;
      end else begin
        e = expected_sends.pop_front();
        if (out_send_kind !== e.send_kind) begin
          $error("send_kind expected %0d got %0d", e.send_kind, out_send_kind);
          error_count++;
        end
        if (out_dest_node !== e.dest_node) begin
          $error("dest_node expected %0d got %0d", e.dest_node, out_dest_node);
          error_count++;
        end
        if (out_out_version !== e.out_version) begin
          $error("out_version expected %0d got %0d", e.out_version, out_out_version);
          error_count++;
        end
        if (out_out_token !== e.out_token) begin
          $error("out_token expected %0d got %0d", e.out_token, out_out_token);
          error_count++;
        end
        if (out_out_hops !== e.out_hops) begin
          $error("out_hops expected %0d got %0d", e.out_hops, out_out_hops);
          error_count++;
        end
        if (out_neighbor_total !== e.neighbor_total) begin
          $error("neighbor_total expected %0d got %0d", e.neighbor_total,
                 out_neighbor_total);
          error_count++;
        end
      end
    end
  end

  // Waits until the driver has handed over everything and every result has come.
  task automatic wait_quiet();
    while (pending_msgs.size() > 0 || start || expected_sends.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes happen only while the node is idle.
  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SINK_MODE) sink_cfg = value[0];
    else lifetime_cfg = value;
    @(posedge clk);
  endtask

  // Announces and ticks grow and age the table; token traffic makes up most of the mix.
  task automatic queue_random(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) pending_msgs.push_back(random_msg(ACT_ANNOUNCE));
      else if (pick < 45) pending_msgs.push_back(random_msg(ACT_TICK));
      else if (pick < 98) pending_msgs.push_back(random_msg(3'($urandom_range(2, 6))));
      else pending_msgs.push_back(random_msg(ACT_UNUSED));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SINK_MODE;
    cfg_data = '0;
    {in_action, in_source_node, in_msg_version, in_msg_token, in_msg_hops,
     in_random_value} = '0;
    error_count = 0;
    drain_hold = 1'b0;
    nbr_count = 0;
    token_held = '0;
    version_held = '0;
    sink_cfg = 1'b0;
    lifetime_cfg = 16'd30;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset values: empty table, extreme fields, every action except tick.
    pending_msgs.push_back(make_msg(ACT_DATA, 16'hFFFF, 16'h7FFF, 32'h7FFFFFFF,
                                    32'h7FFFFFFF, 16'hFFFF));
    pending_msgs.push_back(make_msg(ACT_START, 16'd0, 16'h8000, 32'h80000000,
                                    32'h80000000, 16'd0));
    pending_msgs.push_back(make_msg(ACT_BEACON, 16'hFFFF, 16'h8000, 32'd0, 32'd0, 16'd0));
    pending_msgs.push_back(make_msg(ACT_BEACON, 16'h1234, 16'h7FFF, 32'd0, 32'd0, 16'd0));
    pending_msgs.push_back(make_msg(ACT_RECOVER, 16'd0, 16'h0005, 32'hFFFFFFFF, 32'd0, 16'd0));
    pending_msgs.push_back(make_msg(ACT_BEACON, 16'd9, 16'h0005, 32'd0, 32'd0, 16'd0));
    pending_msgs.push_back(make_msg(ACT_CONTROL, 16'hABCD, 16'd0, 32'd0, 32'd0, 16'd0));
    pending_msgs.push_back(make_msg(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF,
                                    32'hFFFFFFFF, 16'hFFFF));
    // Fill beyond capacity so the table-full case is reached.
    for (int i = 0; i < 17; i++)
      pending_msgs.push_back(make_msg(ACT_ANNOUNCE, 16'(16'hFFF0 + i), 16'd0, 32'd0,
                                      32'd0, 16'd0));
    pending_msgs.push_back(make_msg(ACT_DATA, 16'd0, 16'h8000, 32'd1, 32'hFFFFFFFF, 16'hFFFF));
    pending_msgs.push_back(make_msg(ACT_START, 16'd0, 16'd0, 32'd0, 32'd0, 16'd7));
    wait_quiet();

    // Sink mode and the shortest lifetimes, including zero which acts as one.
    write_reg(CFG_SINK_MODE, 16'd1);
    write_reg(CFG_LIFETIME, 16'd0);
    pending_msgs.push_back(make_msg(ACT_ANNOUNCE, 16'd3, 16'd0, 32'd0, 32'd0, 16'd0));
    pending_msgs.push_back(make_msg(ACT_DATA, 16'd0, 16'd1, 32'd2, 32'd3, 16'd4));
    pending_msgs.push_back(make_msg(ACT_TICK, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0));
    pending_msgs.push_back(make_msg(ACT_TICK, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0));
    queue_random(150);
    // The sender holds off here until every expected result has arrived.
    drain_hold = 1'b1;
    while (start || expected_sends.size() > 0) @(posedge clk);
    drain_hold = 1'b0;
    wait_quiet();

    // Random phases through several register settings, extremes among them.
    write_reg(CFG_SINK_MODE, 16'd0);
    write_reg(CFG_LIFETIME, 16'd1);
    queue_random(150);
    wait_quiet();
    write_reg(CFG_LIFETIME, 16'hFFFF);
    queue_random(250);
    wait_quiet();
    write_reg(CFG_LIFETIME, 16'd4);
    queue_random(250);
    wait_quiet();
    write_reg(CFG_SINK_MODE, 16'd1);
    write_reg(CFG_LIFETIME, 16'd12);
    queue_random(200);
    wait_quiet();
    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_sends.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (expected_sends.size() > 0)
        $error("%0d expected results never arrived", expected_sends.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: ends a run that hangs before its 1031 items are through, reporting mismatches.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
